// ----- hw/rtl/bucket_by_element_sort_core_defines.svh -----
// Assertion macros for the bucket-by-element sort core.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef BUCKET_BY_ELEMENT_SORT_CORE_DEFINES_SVH
`define BUCKET_BY_ELEMENT_SORT_CORE_DEFINES_SVH

// same-cycle implication
`define BBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bbs_pkg.sv -----
// Shared types and constants for the bucket-by-element sort core.
// No dependencies.
package bbs_pkg;

    localparam int FUNC_W   = 2;
    localparam int ELEM_W   = 9;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int PID_W    = 11;
    localparam int OFF_W    = 10;
    localparam int CNT_W    = 11;
    localparam int NUM_EL_W = 9;

    localparam logic [NUM_EL_W-1:0] NUM_EL_RESET = 9'd256;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_SLOT   = 2'd1,
        FUNC_BUCKET = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ELEM  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_BUILT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QUERY,
        S_CLEAR,
        S_CNT_RD,
        S_CNT_EL,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_SC_RD,
        S_SC_EL,
        S_SC_WR
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_QDONE,
        OP_CLR,
        OP_CNT_RD,
        OP_CNT_EL,
        OP_CNT_WR,
        OP_PFX_RD,
        OP_PFX_WR,
        OP_SC_RD,
        OP_SC_EL,
        OP_SC_WR
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic starts_build;
        logic p_done;
        logic e_done;
    } t_dp_stat;

endpackage

// ----- hw/rtl/bbs_if.sv -----
// Request and response channel interfaces for the bucket-by-element sort core.
// Depends on bbs_pkg.
interface bbs_req_if import bbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ELEM_W-1:0] element;
    logic [SLOT_W-1:0] slot;
    logic              last;

    modport source (output valid, func, element, slot, last, input ready);
    modport sink   (input valid, func, element, slot, last, output ready);
endinterface

interface bbs_rsp_if import bbs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    particle_id;
    logic [OFF_W-1:0]    bucket_offset;
    logic [CNT_W-1:0]    bucket_count;

    modport source (output valid, status, particle_id, bucket_offset, bucket_count,
                    input ready);
    modport sink   (input valid, status, particle_id, bucket_offset, bucket_count,
                    output ready);
endinterface

// ----- hw/rtl/bucket_by_element_sort_core.sv -----
// Counting-sort bucket indexer. A load request stores the element of the next
// particle and returns its result in the next cycle; function code 3 likewise.
// A slot or bucket query passes through the registered memory read and the
// query state before its result is registered. One request is in flight at a
// time; the next is taken only once the previous result has gone or goes in the
// same cycle. The load marked last starts a build that holds off requests: a
// count clear over all elements, a count pass and a scatter pass with a read,
// element and write step per particle stored, and a prefix pass with a read
// and a write step per element, each bound by one read and one write port
// per memory.
// The configuration write is always ready and is registered before it takes effect.
// Depends on bbs_pkg, bbs_if, bbs_ctrl, bbs_dpath and the assertion macros.
`include "bucket_by_element_sort_core_defines.svh"

module bucket_by_element_sort_core import bbs_pkg::*; #(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_ELEMENTS  = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bbs_req_if.sink             i_req,
    bbs_rsp_if.source           o_rsp,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [NUM_EL_W-1:0] i_cfg_data
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    assign o_cfg_ready = 1'b1;

    bbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bbs_dpath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_ELEMENTS  (MAX_ELEMENTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_func          (i_req.func),
        .i_element       (i_req.element),
        .i_slot          (i_req.slot),
        .i_last          (i_req.last),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_rsp.status),
        .o_particle_id   (o_rsp.particle_id),
        .o_bucket_offset (o_rsp.bucket_offset),
        .o_bucket_count  (o_rsp.bucket_count)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    `BBS_ASSERT_SAME(a_ready_needs_free_slot, i_req.ready, !o_rsp.valid || o_rsp.ready, "request taken while result register blocked")
    `BBS_ASSERT_SAME(a_no_ready_in_build, w_cmd.op != OP_NONE && w_cmd.op != OP_ACCEPT, !i_req.ready, "request taken outside idle")
    `BBS_ASSERT_NEXT(a_load_result_next, i_req.valid && i_req.ready && i_req.func != FUNC_SLOT && i_req.func != FUNC_BUCKET, o_rsp.valid, "load result missing")
    `BBS_ASSERT_NEXT(a_query_result_late, i_req.valid && i_req.ready && (i_req.func == FUNC_SLOT || i_req.func == FUNC_BUCKET), !o_rsp.valid ##1 o_rsp.valid, "query result timing")

endmodule

// ----- hw/rtl/bbs_ctrl.sv -----
// Sequencer for the bucket-by-element sort core: request handshake, query wait
// and the clear / count / prefix / scatter build passes. Depends on bbs_pkg.
module bbs_ctrl import bbs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_stat.is_query) begin
                        n_state = S_QUERY;
                    end else begin
                        n_out_valid = 1'b1;
                        if (i_stat.starts_build) begin
                            n_state = S_CLEAR;
                        end
                    end
                end
            end
            S_QUERY: begin
                o_cmd.op    = OP_QDONE;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.e_done) begin
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                o_cmd.op = OP_CNT_RD;
                n_state  = i_stat.p_done ? S_PFX_RD : S_CNT_EL;
            end
            S_CNT_EL: begin
                o_cmd.op = OP_CNT_EL;
                n_state  = S_CNT_WR;
            end
            S_CNT_WR: begin
                o_cmd.op = OP_CNT_WR;
                n_state  = S_CNT_RD;
            end
            S_PFX_RD: begin
                o_cmd.op = OP_PFX_RD;
                n_state  = i_stat.e_done ? S_SC_RD : S_PFX_WR;
            end
            S_PFX_WR: begin
                o_cmd.op = OP_PFX_WR;
                n_state  = S_PFX_RD;
            end
            S_SC_RD: begin
                o_cmd.op = OP_SC_RD;
                n_state  = i_stat.p_done ? S_IDLE : S_SC_EL;
            end
            S_SC_EL: begin
                o_cmd.op = OP_SC_EL;
                n_state  = S_SC_WR;
            end
            S_SC_WR: begin
                o_cmd.op = OP_SC_WR;
                n_state  = S_SC_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/bbs_dpath.sv -----
// Datapath of the bucket-by-element sort core: particle, count, offset and
// sorted-list memories, build counters and result register. Depends on bbs_pkg.
module bbs_dpath import bbs_pkg::*; #(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_ELEMENTS  = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [ELEM_W-1:0]   i_element,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_last,
    input  logic                i_cfg_valid,
    input  logic [NUM_EL_W-1:0] i_cfg_data,
    input  t_cmd                i_cmd,
    output t_dp_stat            o_stat,
    output logic [STATUS_W-1:0] o_status,
    output logic [PID_W-1:0]    o_particle_id,
    output logic [OFF_W-1:0]    o_bucket_offset,
    output logic [CNT_W-1:0]    o_bucket_count
);

    localparam int PW  = $clog2(MAX_PARTICLES);
    localparam int LW  = $clog2(MAX_PARTICLES + 1);
    localparam int SW  = LW + 1;
    localparam int EW  = $clog2(MAX_ELEMENTS);
    localparam int ECW = $clog2(MAX_ELEMENTS + 1);

    logic [EW-1:0] pe_mem  [MAX_PARTICLES];
    logic [LW-1:0] cnt_mem [MAX_ELEMENTS];
    logic [LW-1:0] off_mem [MAX_ELEMENTS];
    logic [PW-1:0] srt_mem [MAX_PARTICLES];

    logic [NUM_EL_W-1:0] r_num_el;
    logic [LW-1:0]       r_loaded;
    logic                r_built;
    logic [LW-1:0]       r_pidx;
    logic [ECW-1:0]      r_eidx;
    logic [LW-1:0]       r_run;
    logic [EW-1:0]       r_el;
    logic [EW-1:0]       r_pe_q;
    logic [LW-1:0]       r_cnt_q;
    logic [LW-1:0]       r_off_q;
    logic [PW-1:0]       r_srt_q;
    logic                r_q_slot;
    logic                r_q_hit;
    t_status             r_q_status;
    t_status             r_status;
    logic [PID_W-1:0]    r_pid;
    logic [OFF_W-1:0]    r_off;
    logic [CNT_W-1:0]    r_cnt;

    logic          elem_ok;
    logic [EW-1:0] elem_idx;
    logic [LW-1:0] load_base;
    logic          full;
    logic          slot_ok;
    logic          is_load;
    logic          store_ok;
    logic [SW-1:0] pos;
    logic          pos_ok;
    logic [EW-1:0] pe_raddr;
    logic [EW-1:0] cnt_raddr;
    logic [EW-1:0] off_raddr;
    logic [PW-1:0] pe_raddr_p;
    logic [PW-1:0] srt_raddr;
    logic          cnt_we;
    logic [EW-1:0] cnt_waddr;
    logic [LW-1:0] cnt_wdata;

    assign elem_ok   = (i_element != '0) && (i_element <= r_num_el)
                       && (32'(i_element) <= MAX_ELEMENTS);
    assign elem_idx  = EW'(i_element - ELEM_W'(1));
    assign load_base = r_built ? '0 : r_loaded;
    assign full      = load_base >= LW'(MAX_PARTICLES);
    assign slot_ok   = 32'(i_slot) < 32'(r_loaded);
    assign is_load   = (i_func == FUNC_LOAD);
    assign store_ok  = elem_ok && !full;
    assign pos       = SW'(r_off_q) + SW'(r_cnt_q);
    assign pos_ok    = pos < SW'(MAX_PARTICLES);

    assign o_stat.is_query     = (i_func == FUNC_SLOT) || (i_func == FUNC_BUCKET);
    assign o_stat.starts_build = is_load && i_last;
    assign o_stat.p_done       = (r_pidx == r_loaded);
    assign o_stat.e_done       = (r_eidx == ECW'(MAX_ELEMENTS));

    assign pe_raddr_p = r_pidx[PW-1:0];
    assign pe_raddr   = r_pe_q;
    assign srt_raddr  = PW'(i_slot);
    assign off_raddr  = (i_cmd.op == OP_SC_EL) ? pe_raddr : elem_idx;

    always_comb begin
        case (i_cmd.op) inside
            OP_CNT_EL, OP_SC_EL: cnt_raddr = pe_raddr;
            OP_PFX_RD:           cnt_raddr = r_eidx[EW-1:0];
            default:             cnt_raddr = elem_idx;
        endcase
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_eidx[EW-1:0];
        cnt_wdata = '0;
        case (i_cmd.op) inside
            OP_CLR: begin
                cnt_we = !o_stat.e_done;
            end
            OP_PFX_WR: begin
                cnt_we = 1'b1;
            end
            OP_CNT_WR, OP_SC_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_el;
                cnt_wdata = r_cnt_q + LW'(1);
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT && is_load && store_ok) begin
            pe_mem[load_base[PW-1:0]] <= elem_idx;
        end
        r_pe_q <= pe_mem[pe_raddr_p];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PFX_WR) begin
            off_mem[r_eidx[EW-1:0]] <= r_run;
        end
        r_off_q <= off_mem[off_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SC_WR && pos_ok) begin
            srt_mem[pos[PW-1:0]] <= r_pidx[PW-1:0];
        end
        r_srt_q <= srt_mem[srt_raddr];
    end

    // control state and build counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_el <= NUM_EL_RESET;
            r_loaded <= '0;
            r_built  <= 1'b0;
            r_pidx   <= '0;
            r_eidx   <= '0;
            r_run    <= '0;
            r_el     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_num_el <= i_cfg_data;
            end
            case (i_cmd.op) inside
                OP_ACCEPT: begin
                    r_eidx <= '0;
                    if (is_load) begin
                        r_loaded <= store_ok ? load_base + LW'(1) : load_base;
                        r_built  <= 1'b0;
                    end
                end
                OP_CLR: begin
                    if (!o_stat.e_done) begin
                        r_eidx <= r_eidx + ECW'(1);
                    end else begin
                        r_pidx <= '0;
                    end
                end
                OP_CNT_RD: begin
                    if (o_stat.p_done) begin
                        r_eidx <= '0;
                        r_run  <= '0;
                    end
                end
                OP_CNT_EL, OP_SC_EL: begin
                    r_el <= r_pe_q;
                end
                OP_CNT_WR, OP_SC_WR: begin
                    r_pidx <= r_pidx + LW'(1);
                end
                OP_PFX_RD: begin
                    if (o_stat.e_done) begin
                        r_pidx <= '0;
                    end
                end
                OP_PFX_WR: begin
                    r_run  <= r_run + r_cnt_q;
                    r_eidx <= r_eidx + ECW'(1);
                end
                OP_SC_RD: begin
                    if (o_stat.p_done) begin
                        r_built <= 1'b1;
                    end
                end
                default: begin
                    r_el <= r_el;
                end
            endcase
        end
    end

    // query capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT) begin
            r_q_slot <= (i_func == FUNC_SLOT);
            r_q_hit  <= r_built && ((i_func == FUNC_SLOT) ? slot_ok : elem_ok);
            if (!r_built) begin
                r_q_status <= ST_NOT_BUILT;
            end else if (i_func == FUNC_BUCKET && !elem_ok) begin
                r_q_status <= ST_BAD_ELEM;
            end else begin
                r_q_status <= ST_OK;
            end
            if (!o_stat.is_query) begin
                if (is_load && !elem_ok) begin
                    r_status <= ST_BAD_ELEM;
                end else if (is_load && full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_OK;
                end
                r_pid <= '0;
                r_off <= '0;
                r_cnt <= '0;
            end
        end else if (i_cmd.op == OP_QDONE) begin
            r_status <= r_q_status;
            r_pid    <= (r_q_hit && r_q_slot) ? PID_W'(r_srt_q) + PID_W'(1) : '0;
            r_off    <= (r_q_hit && !r_q_slot) ? OFF_W'(r_off_q) : '0;
            r_cnt    <= (r_q_hit && !r_q_slot) ? CNT_W'(r_cnt_q) : '0;
        end
    end

    assign o_status        = r_status;
    assign o_particle_id   = r_pid;
    assign o_bucket_offset = r_off;
    assign o_bucket_count  = r_cnt;

endmodule
